[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is held off while reset is low
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that must also hold through reset
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/usbdfu_pkg.sv]
// ----------------------------------------------------------------------------
// usbdfu_pkg
// types and codes shared by the firmware-upgrade request core
// ----------------------------------------------------------------------------
package usbdfu_pkg;

  // standard class states
  typedef enum logic [3:0] {
    S_APP_IDLE   = 4'd0,
    S_APP_DETACH = 4'd1,
    S_IDLE       = 4'd2,
    S_DN_SYNC    = 4'd3,
    S_DN_BUSY    = 4'd4,
    S_DN_IDLE    = 4'd5,
    S_MAN_SYNC   = 4'd6,
    S_MAN        = 4'd7,
    S_MAN_WAIT   = 4'd8,
    S_UP_IDLE    = 4'd9,
    S_ERROR      = 4'd10
  } dfu_state_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOTDONE = 2'd1,
    ST_STALL   = 2'd2
  } status_t;

  // event kinds
  localparam logic OP_REQUEST   = 1'b0;
  localparam logic OP_BUS_RESET = 1'b1;

  // class request codes
  localparam logic [2:0] RQ_DETACH    = 3'd0;
  localparam logic [2:0] RQ_DNLOAD    = 3'd1;
  localparam logic [2:0] RQ_UPLOAD    = 3'd2;
  localparam logic [2:0] RQ_GETSTATUS = 3'd3;
  localparam logic [2:0] RQ_CLRSTATUS = 3'd4;
  localparam logic [2:0] RQ_GETSTATE  = 3'd5;
  localparam logic [2:0] RQ_ABORT     = 3'd6;

  // descriptor rewrite commands (attributes at bytes 0x10 and 0x19)
  localparam logic [1:0] DESC_NONE    = 2'd0;
  localparam logic [1:0] DESC_RUNTIME = 2'd1;
  localparam logic [1:0] DESC_DFU     = 2'd2;

  // poll timeout low byte
  localparam logic [7:0] POLL_BUSY  = 8'hFF;
  localparam logic [7:0] POLL_READY = 8'h00;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  request;
    logic [15:0] request_length;
    logic        alt_setting;
    logic        copy_done;
  } req_t;

  typedef struct packed {
    logic [3:0] dfu_state;
    logic [1:0] dfu_status;
    logic       request_ok;
    logic [7:0] poll_timeout;
    logic       target_is_flash;
    logic       flash_unlock;
    logic       flash_lock;
    logic       commit_ram_block;
    logic       clear_image_length;
    logic [1:0] descriptor_write;
    logic       hard_reset;
  } rsp_t;

endpackage

[rtl/core/usbdfu_in_if.sv]
// ----------------------------------------------------------------------------
// usbdfu_in_if
// event channel: valid/ready handshake with one request or bus reset a beat
// ----------------------------------------------------------------------------
interface usbdfu_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [2:0]  request;
  logic [15:0] request_length;
  logic        alt_setting;
  logic        copy_done;

  modport source (
    output valid, opcode, request, request_length, alt_setting, copy_done,
    input  ready
  );
  modport sink (
    input  valid, opcode, request, request_length, alt_setting, copy_done,
    output ready
  );
endinterface

[rtl/core/usbdfu_out_if.sv]
// ----------------------------------------------------------------------------
// usbdfu_out_if
// result channel: valid/ready handshake with one state report a beat
// ----------------------------------------------------------------------------
interface usbdfu_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] dfu_state;
  logic [1:0] dfu_status;
  logic       request_ok;
  logic [7:0] poll_timeout;
  logic       target_is_flash;
  logic       flash_unlock;
  logic       flash_lock;
  logic       commit_ram_block;
  logic       clear_image_length;
  logic [1:0] descriptor_write;
  logic       hard_reset;

  modport source (
    output valid, dfu_state, dfu_status, request_ok, poll_timeout, target_is_flash,
           flash_unlock, flash_lock, commit_ram_block, clear_image_length,
           descriptor_write, hard_reset,
    input  ready
  );
  modport sink (
    input  valid, dfu_state, dfu_status, request_ok, poll_timeout, target_is_flash,
           flash_unlock, flash_lock, commit_ram_block, clear_image_length,
           descriptor_write, hard_reset,
    output ready
  );
endinterface

[rtl/core/usbdfu_in_stage.sv]
// ----------------------------------------------------------------------------
// usbdfu_in_stage
// input register holding one event beat until the decode takes it
// ----------------------------------------------------------------------------
module usbdfu_in_stage import usbdfu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  input  logic advance,
  output logic req_vld,
  output req_t req_q
);

  logic vld_r;
  logic vld_nxt;
  req_t req_r;

  assign in_ready = !vld_r || advance;
  assign vld_nxt  = in_valid || (vld_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_ready ? vld_nxt : vld_r;
    end
  end

  // payload register, loaded on every accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
  end

  assign req_vld = vld_r;
  assign req_q   = req_r;

endmodule

[rtl/core/usbdfu_fsm.sv]
// ----------------------------------------------------------------------------
// usbdfu_fsm
// class state, sticky status, poll byte, target and copy flag with their decode
// ----------------------------------------------------------------------------
module usbdfu_fsm import usbdfu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  req_t req,
  output rsp_t rsp
);

  dfu_state_t state_r, state_nxt;
  status_t    status_r, status_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic       flash_r, flash_nxt;
  logic       copy_r, copy_nxt;

  logic       is_reset;
  logic       len_zero;

  assign is_reset = (req.opcode == OP_BUS_RESET);
  assign len_zero = (req.request_length == 16'd0);

  // next state
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    poll_nxt   = poll_r;
    flash_nxt  = flash_r;
    copy_nxt   = copy_r;
    if (is_reset) begin
      if (state_r == S_APP_DETACH) begin
        state_nxt  = S_IDLE;
        status_nxt = ST_OK;
      end else if (state_r != S_APP_IDLE && state_r != S_IDLE) begin
        state_nxt  = S_APP_IDLE;
        status_nxt = ST_OK;
      end
    end else begin
      unique case (state_r)
        S_APP_IDLE: begin
          if (req.request == RQ_DETACH) begin
            state_nxt = S_APP_DETACH;
          end else if (req.request != RQ_GETSTATUS && req.request != RQ_GETSTATE) begin
            status_nxt = ST_STALL;
          end
        end
        S_APP_DETACH: begin
          if (req.request != RQ_GETSTATUS && req.request != RQ_GETSTATE) begin
            state_nxt  = S_APP_IDLE;
            status_nxt = ST_STALL;
          end
        end
        S_IDLE: begin
          priority if (req.request == RQ_DNLOAD) begin
            if (!len_zero) begin
              state_nxt = S_DN_SYNC;
              flash_nxt = req.alt_setting;
            end else begin
              state_nxt  = S_ERROR;
              status_nxt = ST_NOTDONE;
            end
          end else if (req.request == RQ_UPLOAD) begin
            state_nxt = S_UP_IDLE;
          end else if (req.request == RQ_ABORT) begin
            status_nxt = ST_OK;
          end else if (req.request != RQ_GETSTATUS && req.request != RQ_GETSTATE) begin
            state_nxt  = S_ERROR;
            status_nxt = ST_STALL;
          end
        end
        S_DN_SYNC: begin
          if (req.request == RQ_GETSTATUS) begin
            if (flash_r) begin
              if (!copy_r) begin
                copy_nxt = 1'b1;
                poll_nxt = POLL_BUSY;
              end else if (req.copy_done) begin
                copy_nxt  = 1'b0;
                poll_nxt  = POLL_READY;
                state_nxt = S_DN_IDLE;
              end
            end else begin
              state_nxt = S_DN_IDLE;
            end
          end else if (req.request != RQ_GETSTATE) begin
            state_nxt  = S_ERROR;
            status_nxt = ST_STALL;
          end
        end
        S_DN_BUSY: begin
          state_nxt = S_DN_SYNC;
        end
        S_DN_IDLE: begin
          if (req.request == RQ_DNLOAD) begin
            state_nxt = len_zero ? S_MAN_SYNC : S_DN_SYNC;
          end else if (req.request == RQ_ABORT || req.request == RQ_GETSTATUS ||
                       req.request == RQ_GETSTATE) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt  = S_ERROR;
            status_nxt = ST_STALL;
          end
        end
        S_MAN_SYNC: begin
          if (req.request == RQ_GETSTATUS) begin
            state_nxt  = S_MAN_WAIT;
            status_nxt = ST_OK;
          end else if (req.request != RQ_GETSTATE) begin
            state_nxt  = S_ERROR;
            status_nxt = ST_STALL;
          end
        end
        S_MAN: begin
          state_nxt  = S_MAN_WAIT;
          status_nxt = ST_OK;
        end
        S_MAN_WAIT, S_UP_IDLE, S_ERROR: begin
          state_nxt = state_r;
        end
        default: begin
          state_nxt  = S_ERROR;
          status_nxt = ST_STALL;
        end
      endcase
    end
  end

  // result and command pulses
  always_comb begin
    rsp                    = '0;
    rsp.dfu_state          = state_nxt;
    rsp.dfu_status         = status_nxt;
    rsp.request_ok         = (status_nxt == ST_OK);
    rsp.poll_timeout       = poll_nxt;
    rsp.target_is_flash    = flash_nxt;
    if (is_reset) begin
      rsp.clear_image_length = 1'b1;
      if (state_r == S_APP_DETACH) begin
        rsp.descriptor_write = DESC_DFU;
      end else if (state_r != S_APP_IDLE && state_r != S_IDLE) begin
        rsp.descriptor_write = DESC_RUNTIME;
        rsp.hard_reset       = 1'b1;
      end
    end else begin
      if (state_r == S_IDLE && req.request == RQ_DNLOAD && !len_zero) begin
        rsp.clear_image_length = 1'b1;
        rsp.flash_unlock       = req.alt_setting;
      end
      if (state_r == S_DN_SYNC && req.request == RQ_GETSTATUS && !flash_r) begin
        rsp.commit_ram_block = 1'b1;
      end
      if (state_r == S_DN_IDLE && req.request == RQ_DNLOAD && len_zero) begin
        rsp.flash_lock = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_APP_IDLE;
      status_r <= ST_OK;
      poll_r   <= POLL_READY;
      flash_r  <= 1'b0;
      copy_r   <= 1'b0;
    end else if (advance) begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      poll_r   <= poll_nxt;
      flash_r  <= flash_nxt;
      copy_r   <= copy_nxt;
    end
  end

endmodule

[rtl/core/usbdfu_out_stage.sv]
// ----------------------------------------------------------------------------
// usbdfu_out_stage
// result register holding one report beat until the sink takes it
// ----------------------------------------------------------------------------
module usbdfu_out_stage import usbdfu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  rsp_t rsp,
  input  logic out_ready,
  output logic out_valid,
  output rsp_t rsp_q
);

  logic vld_r;
  rsp_t rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_r <= rsp;
    end
  end

  assign out_valid = vld_r;
  assign rsp_q     = rsp_r;

endmodule

[rtl/core/usb_dfu_request_state_machine_core.sv]
// ----------------------------------------------------------------------------
// usb_dfu_request_state_machine_core
// Device side of the firmware-upgrade class state machine. Each input beat is
// one event, a class request (code, wLength, alternate setting, copy-done
// flag) or a bus reset, and gives exactly one result beat with the new state,
// the sticky status, the poll timeout low byte, the RAM or flash target and
// single-beat commands for flash unlock and lock, RAM block commit, image
// length clear, descriptor attribute rewrite and chip hard reset. An event
// passes an input register and then a result register, with the state
// decode combinational between them; a new event is taken every cycle while
// the result side keeps up. The input side keeps taking beats while a result
// waits, until both registers are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module usb_dfu_request_state_machine_core import usbdfu_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  usbdfu_in_if.sink     in_ch,
  usbdfu_out_if.source  out_ch
);

  req_t in_req;
  req_t req_q;
  logic req_vld;
  logic advance;
  rsp_t rsp;
  rsp_t rsp_q;
  logic out_vld;

  // gather the event beat
  assign in_req.opcode         = in_ch.opcode;
  assign in_req.request        = in_ch.request;
  assign in_req.request_length = in_ch.request_length;
  assign in_req.alt_setting    = in_ch.alt_setting;
  assign in_req.copy_done      = in_ch.copy_done;

  // decode fires when an event is held and the result slot is free or emptying
  assign advance = req_vld && (!out_vld || out_ch.ready);

  usbdfu_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_req   (in_req),
    .advance  (advance),
    .req_vld  (req_vld),
    .req_q    (req_q)
  );

  // state registers and next-state decode
  usbdfu_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (req_q),
    .rsp     (rsp)
  );

  usbdfu_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .rsp       (rsp),
    .out_ready (out_ch.ready),
    .out_valid (out_vld),
    .rsp_q     (rsp_q)
  );

  // spread the result beat onto the channel
  assign out_ch.valid              = out_vld;
  assign out_ch.dfu_state          = rsp_q.dfu_state;
  assign out_ch.dfu_status         = rsp_q.dfu_status;
  assign out_ch.request_ok         = rsp_q.request_ok;
  assign out_ch.poll_timeout       = rsp_q.poll_timeout;
  assign out_ch.target_is_flash    = rsp_q.target_is_flash;
  assign out_ch.flash_unlock       = rsp_q.flash_unlock;
  assign out_ch.flash_lock         = rsp_q.flash_lock;
  assign out_ch.commit_ram_block   = rsp_q.commit_ram_block;
  assign out_ch.clear_image_length = rsp_q.clear_image_length;
  assign out_ch.descriptor_write   = rsp_q.descriptor_write;
  assign out_ch.hard_reset         = rsp_q.hard_reset;

  // a decoded bus reset always shows up next cycle with the image length clear
  `ASSERT_CLK(a_bus_reset_clears, advance && req_q.opcode == OP_BUS_RESET |=> out_vld && rsp_q.clear_image_length, "bus reset beat lost its clear command")

  // runtime descriptor rewrite only comes with a hard reset back to app idle
  `ASSERT_CLK(a_runtime_desc_reset, out_vld && rsp_q.descriptor_write == DESC_RUNTIME |-> rsp_q.hard_reset && rsp_q.dfu_state == S_APP_IDLE, "runtime descriptor without hard reset")

  // flash unlock implies the flash target
  `ASSERT_CLK(a_unlock_flash, out_vld && rsp_q.flash_unlock |-> rsp_q.target_is_flash, "flash unlock with ram target")

  // both registers full and result stalled: no beat may enter
  `ASSERT_ALWAYS(a_full_backpressure, req_vld && out_vld && !out_ch.ready |-> !in_ch.ready, "beat accepted with pipeline full")

endmodule

[tb/usbdfu_state_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbdfu_state_checker
// Watches the event and result channels of the firmware-upgrade request core,
// predicts each state report from the accepted events and compares it field by
// field with the report beat that comes out.
// ----------------------------------------------------------------------------
module usbdfu_state_checker import usbdfu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  usbdfu_in_if        in_ch,
  usbdfu_out_if       out_ch,
  input  logic        run_done,
  output int unsigned mismatches,
  output int unsigned reports_checked,
  output int unsigned backlog
);

  // predicted device state
  dfu_state_t cur_state;
  status_t    cur_status;
  logic [7:0] poll_byte;
  logic       flash_tgt;
  logic       copy_busy;
  logic       leftover_seen;

  rsp_t expected_reports[$];

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("%0t ns  mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic void enter_stall();
    cur_state  = S_ERROR;
    cur_status = ST_STALL;
  endfunction

  // next state report for one event, updating the predicted state
  function automatic rsp_t advance_dfu(input req_t ev);
    rsp_t r;
    r = '0;
    if (ev.opcode == OP_BUS_RESET) begin
      r.clear_image_length = 1'b1;
      if (cur_state == S_APP_DETACH) begin
        cur_state  = S_IDLE;
        cur_status = ST_OK;
        r.descriptor_write = DESC_DFU;
      end else if (cur_state != S_APP_IDLE && cur_state != S_IDLE) begin
        cur_state  = S_APP_IDLE;
        cur_status = ST_OK;
        r.descriptor_write = DESC_RUNTIME;
        r.hard_reset = 1'b1;
      end
    end else begin
      case (cur_state)
        S_APP_IDLE: begin
          if (ev.request == RQ_DETACH) cur_state = S_APP_DETACH;
          else if (ev.request != RQ_GETSTATUS && ev.request != RQ_GETSTATE)
            cur_status = ST_STALL;
        end
        S_APP_DETACH: begin
          if (ev.request != RQ_GETSTATUS && ev.request != RQ_GETSTATE) begin
            cur_state  = S_APP_IDLE;
            cur_status = ST_STALL;
          end
        end
        S_IDLE: begin
          if (ev.request == RQ_DNLOAD) begin
            if (ev.request_length != 16'd0) begin
              r.clear_image_length = 1'b1;
              cur_state      = S_DN_SYNC;
              flash_tgt      = ev.alt_setting;
              r.flash_unlock = ev.alt_setting;
            end else begin
              cur_state  = S_ERROR;
              cur_status = ST_NOTDONE;
            end
          end else if (ev.request == RQ_UPLOAD) begin
            cur_state = S_UP_IDLE;
          end else if (ev.request == RQ_ABORT) begin
            cur_status = ST_OK;
          end else if (ev.request != RQ_GETSTATUS && ev.request != RQ_GETSTATE) begin
            enter_stall();
          end
        end
        S_DN_SYNC: begin
          if (ev.request == RQ_GETSTATUS) begin
            if (flash_tgt) begin
              if (!copy_busy) begin
                copy_busy = 1'b1;
                poll_byte = POLL_BUSY;
              end else if (ev.copy_done) begin
                poll_byte = POLL_READY;
                copy_busy = 1'b0;
                cur_state = S_DN_IDLE;
              end
            end else begin
              cur_state = S_DN_IDLE;
              r.commit_ram_block = 1'b1;
            end
          end else if (ev.request != RQ_GETSTATE) begin
            enter_stall();
          end
        end
        S_DN_BUSY: cur_state = S_DN_SYNC;
        S_DN_IDLE: begin
          if (ev.request == RQ_DNLOAD) begin
            if (ev.request_length != 16'd0) begin
              cur_state = S_DN_SYNC;
            end else begin
              cur_state = S_MAN_SYNC;
              r.flash_lock = 1'b1;
            end
          end else if (ev.request == RQ_ABORT || ev.request == RQ_GETSTATUS ||
                       ev.request == RQ_GETSTATE) begin
            cur_state = S_IDLE;
          end else begin
            enter_stall();
          end
        end
        S_MAN_SYNC: begin
          if (ev.request == RQ_GETSTATUS) begin
            cur_state  = S_MAN_WAIT;
            cur_status = ST_OK;
          end else if (ev.request != RQ_GETSTATE) begin
            enter_stall();
          end
        end
        S_MAN: begin
          cur_state  = S_MAN_WAIT;
          cur_status = ST_OK;
        end
        S_MAN_WAIT, S_UP_IDLE, S_ERROR: ;
        default: enter_stall();
      endcase
    end
    r.dfu_state       = cur_state;
    r.dfu_status      = cur_status;
    r.request_ok      = (cur_status == ST_OK);
    r.poll_timeout    = poll_byte;
    r.target_is_flash = flash_tgt;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    req_t ev;
    rsp_t want;
    if (!rst_n) begin
      cur_state       = S_APP_IDLE;
      cur_status      = ST_OK;
      poll_byte       = 8'h00;
      flash_tgt       = 1'b0;
      copy_busy       = 1'b0;
      leftover_seen   = 1'b0;
      mismatches      = 0;
      reports_checked = 0;
      expected_reports.delete();
      backlog <= 0;
    end else begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        ev.opcode         = in_ch.opcode;
        ev.request        = in_ch.request;
        ev.request_length = in_ch.request_length;
        ev.alt_setting    = in_ch.alt_setting;
        ev.copy_done      = in_ch.copy_done;
        expected_reports.push_back(advance_dfu(ev));
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result beat with no event waiting");
        end else begin
          want = expected_reports.pop_front();
          check_field("dfu_state", 16'(out_ch.dfu_state), 16'(want.dfu_state));
          check_field("dfu_status", 16'(out_ch.dfu_status), 16'(want.dfu_status));
          check_field("request_ok", 16'(out_ch.request_ok), 16'(want.request_ok));
          check_field("poll_timeout", 16'(out_ch.poll_timeout),
                      16'(want.poll_timeout));
          check_field("target_is_flash", 16'(out_ch.target_is_flash),
                      16'(want.target_is_flash));
          check_field("flash_unlock", 16'(out_ch.flash_unlock),
                      16'(want.flash_unlock));
          check_field("flash_lock", 16'(out_ch.flash_lock), 16'(want.flash_lock));
          check_field("commit_ram_block", 16'(out_ch.commit_ram_block),
                      16'(want.commit_ram_block));
          check_field("clear_image_length", 16'(out_ch.clear_image_length),
                      16'(want.clear_image_length));
          check_field("descriptor_write", 16'(out_ch.descriptor_write),
                      16'(want.descriptor_write));
          check_field("hard_reset", 16'(out_ch.hard_reset), 16'(want.hard_reset));
          reports_checked++;
        end
      end
      if (run_done && !leftover_seen && expected_reports.size() != 0) begin
        leftover_seen = 1'b1;
        report_mismatch($sformatf("%0d expected reports never arrived",
                                  expected_reports.size()));
      end
      backlog <= expected_reports.size();
    end
  end

endmodule

[tb/tb_usb_dfu_request_state_machine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usb_dfu_request_state_machine_core
// Drives class requests and bus resets into the firmware-upgrade request core:
// a short directed walk through the download, flash copy, manifest and reset
// paths, then random sessions (mostly well-formed downloads with random
// content, plus upload, error, run-time and noise sessions). Sender bursts and
// receiver stall patterns vary throughout; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_usb_dfu_request_state_machine_core;
  import usbdfu_pkg::*;

  // request code with no meaning to the class
  localparam logic [2:0] RQ_UNKNOWN = 3'd7;

  // total events to send, directed part included
  localparam int unsigned EVENT_TARGET = 1775;

  // receiver stall patterns
  typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst_n;
  logic run_done;

  int unsigned mismatches;
  int unsigned reports_checked;
  int unsigned backlog;

  // sender bookkeeping
  int unsigned burst_left;
  int unsigned events_sent;
  int unsigned bus_resets_sent;
  int unsigned sessions;
  int unsigned holds_done;

  usbdfu_in_if  ev_ch ();
  usbdfu_out_if rpt_ch ();

  usb_dfu_request_state_machine_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (ev_ch),
    .out_ch (rpt_ch)
  );

  usbdfu_state_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (ev_ch),
    .out_ch          (rpt_ch),
    .run_done        (run_done),
    .mismatches      (mismatches),
    .reports_checked (reports_checked),
    .backlog         (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_usb_dfu_request_state_machine_core NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // event builders
  // ---------------------------------------------------------------------------
  function automatic req_t make_event(input logic op, input logic [2:0] rq,
                                      input logic [15:0] len, input logic alt,
                                      input logic done);
    req_t ev;
    ev.opcode         = op;
    ev.request        = rq;
    ev.request_length = len;
    ev.alt_setting    = alt;
    ev.copy_done      = done;
    return ev;
  endfunction

  // request with everything but the code left to chance
  function automatic req_t rand_fields(input logic [2:0] rq);
    return make_event(OP_REQUEST, rq, 16'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  // bus reset: the other fields are don't-care, so scramble them
  function automatic req_t bus_reset_event();
    return make_event(OP_BUS_RESET, 3'($urandom), 16'($urandom), 1'($urandom),
                      1'($urandom));
  endfunction

  // anything at all, bus resets at about one in four
  function automatic req_t rand_event();
    if ($urandom_range(0, 3) == 0) return bus_reset_event();
    return rand_fields(3'($urandom_range(0, 7)));
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one beat per call, bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  task automatic send_event(input req_t ev);
    int unsigned gap;
    if (burst_left == 0) begin
      // about a third of bursts run on with no gap at all
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        ev_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    ev_ch.valid          <= 1'b1;
    ev_ch.opcode         <= ev.opcode;
    ev_ch.request        <= ev.request;
    ev_ch.request_length <= ev.request_length;
    ev_ch.alt_setting    <= ev.alt_setting;
    ev_ch.copy_done      <= ev.copy_done;
    // hold the beat until the core takes it
    do @(posedge clk); while (ev_ch.ready !== 1'b1);
    burst_left--;
    events_sent++;
    if (ev.opcode == OP_BUS_RESET) bus_resets_sent++;
  endtask

  // stop offering and let every predicted report come back
  task automatic wait_drained();
    int unsigned guard;
    ev_ch.valid <= 1'b0;
    burst_left = 0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (backlog != 0 && guard < 20000);
  endtask

  // ---------------------------------------------------------------------------
  // session builders
  // ---------------------------------------------------------------------------

  // from any state: reset lands in appIDLE or dfuIDLE, upload then sends both
  // to appIDLE after the next reset, detach plus reset then enters dfuIDLE
  task automatic enter_dfu();
    send_event(bus_reset_event());
    send_event(rand_fields(RQ_UPLOAD));
    send_event(bus_reset_event());
    send_event(rand_fields(RQ_DETACH));
    send_event(bus_reset_event());
  endtask

  task automatic download_session();
    logic        to_flash;
    int unsigned blocks;
    enter_dfu();
    to_flash = 1'($urandom);
    send_event(make_event(OP_REQUEST, RQ_DNLOAD, 16'($urandom_range(1, 65535)),
                          to_flash, 1'($urandom)));
    blocks = $urandom_range(1, 4);
    for (int b = 0; b < blocks; b++) begin
      if ($urandom_range(0, 3) == 0) send_event(rand_fields(RQ_GETSTATE));
      if (to_flash) begin
        // first poll starts the copy, later ones wait on copy_done
        repeat ($urandom_range(1, 4))
          send_event(make_event(OP_REQUEST, RQ_GETSTATUS, 16'($urandom),
                                1'($urandom), 1'b0));
        send_event(make_event(OP_REQUEST, RQ_GETSTATUS, 16'($urandom),
                              1'($urandom), 1'b1));
      end else begin
        send_event(rand_fields(RQ_GETSTATUS));
      end
      // the odd stray beat breaks the sequence now and then
      if ($urandom_range(0, 15) == 0) send_event(rand_event());
      if (b + 1 < blocks)
        send_event(make_event(OP_REQUEST, RQ_DNLOAD, 16'($urandom_range(1, 65535)),
                              1'($urandom), 1'($urandom)));
    end
    if ($urandom_range(0, 5) == 0) begin
      // leave download without manifesting
      case ($urandom_range(0, 2))
        0:       send_event(rand_fields(RQ_ABORT));
        1:       send_event(rand_fields(RQ_GETSTATUS));
        default: send_event(rand_fields(RQ_GETSTATE));
      endcase
    end else begin
      send_event(make_event(OP_REQUEST, RQ_DNLOAD, 16'd0, 1'($urandom), 1'($urandom)));
      if ($urandom_range(0, 2) == 0) send_event(rand_fields(RQ_GETSTATE));
      send_event(rand_fields(RQ_GETSTATUS));
      repeat ($urandom_range(0, 2)) send_event(rand_fields(3'($urandom_range(0, 7))));
    end
    send_event(bus_reset_event());
  endtask

  task automatic upload_session();
    enter_dfu();
    send_event(rand_fields(RQ_UPLOAD));
    repeat ($urandom_range(1, 4)) send_event(rand_fields(3'($urandom_range(0, 7))));
    send_event(bus_reset_event());
  endtask

  task automatic error_session();
    enter_dfu();
    case ($urandom_range(0, 3))
      0:       send_event(make_event(OP_REQUEST, RQ_DNLOAD, 16'd0, 1'($urandom),
                                     1'($urandom)));
      1:       send_event(rand_fields(RQ_DETACH));
      2:       send_event(rand_fields(RQ_CLRSTATUS));
      default: send_event(rand_fields(RQ_UNKNOWN));
    endcase
    repeat ($urandom_range(1, 4)) send_event(rand_fields(3'($urandom_range(0, 7))));
    send_event(bus_reset_event());
  endtask

  // run-time side: appIDLE and appDETACH
  task automatic app_session();
    send_event(bus_reset_event());
    send_event(rand_fields(RQ_UPLOAD));
    send_event(bus_reset_event());
    repeat ($urandom_range(1, 5)) send_event(rand_fields(3'($urandom_range(0, 7))));
    send_event(bus_reset_event());
  endtask

  task automatic noise_session();
    repeat ($urandom_range(3, 10)) send_event(rand_event());
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall patterns, plus recurring long hold-offs so the
  // core's two registers fill and input stalls
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned cyc;
    int unsigned hold;
    rx_mode_t    mode;
    cyc  = 0;
    hold = 0;
    mode = RX_ALWAYS;
    holds_done = 0;
    rpt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0) mode = rx_mode_t'($urandom_range(0, 3));
      if (cyc % 2000 == 700) begin
        hold = 80;
        holds_done++;
      end
      if (hold != 0) begin
        hold--;
        rpt_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS: rpt_ch.ready <= 1'b1;
          RX_COIN:   rpt_ch.ready <= 1'($urandom);
          RX_EVERY4: rpt_ch.ready <= (cyc % 4 != 0);
          default:   rpt_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    burst_left      = 0;
    events_sent     = 0;
    bus_resets_sent = 0;
    sessions        = 0;
    rst_n                <= 1'b0;
    run_done             <= 1'b0;
    ev_ch.valid          <= 1'b0;
    ev_ch.opcode         <= OP_REQUEST;
    ev_ch.request        <= RQ_DETACH;
    ev_ch.request_length <= 16'd0;
    ev_ch.alt_setting    <= 1'b0;
    ev_ch.copy_done      <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk: run-time side, enter firmware mode, flash download with
    // copy handshake, manifest, hard reset, then upload and clear-status
    send_event(make_event(OP_REQUEST, RQ_GETSTATUS, 16'hFFFF, 1'b1, 1'b1));
    send_event(make_event(OP_BUS_RESET, RQ_ABORT, 16'hFFFF, 1'b1, 1'b1));
    // unknown request code stalls in appIDLE
    send_event(make_event(OP_REQUEST, RQ_UNKNOWN, 16'h0000, 1'b0, 1'b0));
    send_event(make_event(OP_REQUEST, RQ_DETACH, 16'h0000, 1'b0, 1'b0));
    send_event(make_event(OP_REQUEST, RQ_GETSTATE, 16'h8000, 1'b0, 1'b1));
    // reset from appDETACH: into dfuIDLE with the firmware-mode descriptor
    send_event(make_event(OP_BUS_RESET, RQ_DNLOAD, 16'h0000, 1'b0, 1'b0));
    send_event(make_event(OP_REQUEST, RQ_ABORT, 16'h0001, 1'b0, 1'b0));
    send_event(make_event(OP_REQUEST, RQ_DNLOAD, 16'hFFFF, 1'b1, 1'b0));
    send_event(make_event(OP_REQUEST, RQ_GETSTATE, 16'h0000, 1'b0, 1'b1));
    // flash copy: start, still busy, done
    send_event(make_event(OP_REQUEST, RQ_GETSTATUS, 16'h0000, 1'b1, 1'b0));
    send_event(make_event(OP_REQUEST, RQ_GETSTATUS, 16'h0000, 1'b1, 1'b0));
    send_event(make_event(OP_REQUEST, RQ_GETSTATUS, 16'h0000, 1'b1, 1'b1));
    send_event(make_event(OP_REQUEST, RQ_DNLOAD, 16'h0001, 1'b0, 1'b0));
    send_event(make_event(OP_REQUEST, RQ_GETSTATUS, 16'h0000, 1'b0, 1'b1));
    send_event(make_event(OP_REQUEST, RQ_GETSTATUS, 16'h0000, 1'b0, 1'b1));
    // zero-length download ends it and relocks flash
    send_event(make_event(OP_REQUEST, RQ_DNLOAD, 16'h0000, 1'b1, 1'b0));
    send_event(make_event(OP_REQUEST, RQ_GETSTATUS, 16'h0000, 1'b0, 1'b0));
    send_event(make_event(OP_REQUEST, RQ_GETSTATUS, 16'h0000, 1'b0, 1'b0));
    // reset from wait-reset: hard reset and run-time descriptor
    send_event(make_event(OP_BUS_RESET, RQ_GETSTATUS, 16'h0000, 1'b0, 1'b0));
    send_event(make_event(OP_REQUEST, RQ_DETACH, 16'h0000, 1'b0, 1'b0));
    send_event(make_event(OP_BUS_RESET, RQ_DETACH, 16'h0000, 1'b0, 1'b0));
    // upload state ignores every request, clrstatus included
    send_event(make_event(OP_REQUEST, RQ_UPLOAD, 16'h00FF, 1'b0, 1'b0));
    send_event(make_event(OP_REQUEST, RQ_CLRSTATUS, 16'h0000, 1'b0, 1'b0));
    send_event(make_event(OP_BUS_RESET, RQ_UPLOAD, 16'h0000, 1'b0, 1'b0));

    // sender pauses until the core has nothing left in flight
    wait_drained();

    // random sessions, mostly well-formed downloads
    while (events_sent < EVENT_TARGET) begin
      case ($urandom_range(0, 9))
        5:       upload_session();
        6:       error_session();
        7:       app_session();
        8:       noise_session();
        default: download_session();
      endcase
      sessions++;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    // wait out any stray beat before the leftover check
    repeat (8) @(posedge clk);
    run_done <= 1'b1;
    repeat (3) @(posedge clk);

    $display("sent %0d events (%0d bus resets) over %0d random sessions",
             events_sent, bus_resets_sent, sessions);
    $display("compared %0d result beats; receiver held off %0d times",
             reports_checked, holds_done);
    if (mismatches == 0) begin
      $display("tb_usb_dfu_request_state_machine_core OK");
    end else begin
      $display("tb_usb_dfu_request_state_machine_core NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/usbdfu_pkg.sv
rtl/core/usbdfu_in_if.sv
rtl/core/usbdfu_out_if.sv
rtl/core/usbdfu_in_stage.sv
rtl/core/usbdfu_fsm.sv
rtl/core/usbdfu_out_stage.sv
rtl/core/usb_dfu_request_state_machine_core.sv
tb/usbdfu_state_checker.sv
tb/tb_usb_dfu_request_state_machine_core.sv
